[rtl/core/mcpf_pkg.sv]
// Shared types, constants and the microprogram for the motor command packet framer.
// Holds the control word layout, the CRC-16/XMODEM byte update and the control store.
// No dependencies.
package mcpf_pkg;

  localparam int PC_W = 6;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [1:0] {
    OP_DRIVE,
    OP_PID,
    OP_RESET_ENC,
    OP_ESTOP
  } op_t;

  typedef enum logic [0:0] {
    CFG_DEVICE_ADDRESS,
    CFG_COUNTS_PER_METER
  } cfg_idx_t;

  // Byte source for the output register; SRC_NONE marks a step that emits nothing.
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_ADDR,
    SRC_CMD,
    SRC_WORD,
    SRC_CRC_HI,
    SRC_CRC_LO
  } src_t;

  typedef enum logic [1:0] {
    CSEL_VEL_FIRST,
    CSEL_VEL_SECOND,
    CSEL_PID,
    CSEL_RESET_ENC
  } cmd_sel_t;

  typedef enum logic [2:0] {
    WSEL_CNT_A,
    WSEL_CNT_B,
    WSEL_GAIN_D,
    WSEL_GAIN_P,
    WSEL_GAIN_I,
    WSEL_MAX
  } word_sel_t;

  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_MUL_L,
    ALU_MUL_R,
    ALU_SAT_A,
    ALU_SAT_B,
    ALU_ZERO
  } alu_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_DISPATCH,
    JMP_END
  } jmp_t;

  typedef struct packed {
    src_t      src;
    cmd_sel_t  cmd;
    word_sel_t word;
    logic [1:0] byte_idx;
    logic      crc_clr;
    logic      pkt_end;
    logic      item_end;
    alu_t      alu;
    jmp_t      jmp;
    pc_t       target;
  } ctrl_t;

  // Sequencer to datapath.
  typedef struct packed {
    ctrl_t cw;
    logic  go;
    logic  busy;
  } dp_ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic in_fire;
    op_t  opcode;
    logic stop_active;
    logic stop_level;
    logic out_free;
  } dp_stat_t;

  localparam logic [7:0]  CMD_VEL_FIRST  = 8'd35;
  localparam logic [7:0]  CMD_VEL_SECOND = 8'd36;
  localparam logic [7:0]  CMD_PID_FIRST  = 8'd28;
  localparam logic [7:0]  CMD_PID_SECOND = 8'd29;
  localparam logic [7:0]  CMD_RESET_ENC  = 8'd20;
  localparam logic [15:0] CRC_POLY       = 16'h1021;

  localparam logic [7:0]  ADDR_RESET = 8'd128;
  localparam logic [31:0] CPM_RESET  = 32'd22181415;

  localparam logic [63:0] ROUND_HALF = 64'h0000_0000_0080_0000;
  localparam logic [39:0] POS_LIMIT  = 40'h00_7FFF_FFFF;
  localparam logic [39:0] NEG_LIMIT  = 40'h00_8000_0000;
  localparam logic [31:0] INT32_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] INT32_MIN  = 32'h8000_0000;

  // Entry points of the microprogram.
  localparam pc_t PC_DISPATCH  = 6'd0;
  localparam pc_t PC_DRIVE     = 6'd1;
  localparam pc_t PC_VEL       = 6'd5;
  localparam pc_t PC_ESTOP     = 6'd21;
  localparam pc_t PC_PID       = 6'd22;
  localparam pc_t PC_RESET_ENC = 6'd42;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic ctrl_t cw_idle();
    ctrl_t c;
    c.src      = SRC_NONE;
    c.cmd      = CSEL_VEL_FIRST;
    c.word     = WSEL_CNT_A;
    c.byte_idx = 2'd0;
    c.crc_clr  = 1'b0;
    c.pkt_end  = 1'b0;
    c.item_end = 1'b0;
    c.alu      = ALU_NONE;
    c.jmp      = JMP_NEXT;
    c.target   = PC_DISPATCH;
    return c;
  endfunction

  function automatic ctrl_t cw_alu(alu_t a);
    ctrl_t c;
    c = cw_idle();
    c.alu = a;
    return c;
  endfunction

  function automatic ctrl_t cw_byte(src_t s, cmd_sel_t cs, word_sel_t w, logic [1:0] i);
    ctrl_t c;
    c = cw_idle();
    c.src      = s;
    c.cmd      = cs;
    c.word     = w;
    c.byte_idx = i;
    c.crc_clr  = (s == SRC_ADDR);
    return c;
  endfunction

  function automatic ctrl_t cw_crc_lo(logic last);
    ctrl_t c;
    c = cw_byte(SRC_CRC_LO, CSEL_VEL_FIRST, WSEL_CNT_A, 2'd0);
    c.pkt_end  = 1'b1;
    c.item_end = last;
    c.jmp      = last ? JMP_END : JMP_NEXT;
    return c;
  endfunction

  // Control store. Byte index 0 is the most significant byte of a word.
  function automatic ctrl_t mcpf_rom(pc_t pc);
    ctrl_t c;
    case (pc)
      6'd0: begin
        c = cw_idle();
        c.jmp = JMP_DISPATCH;
      end
      // Drive: convert both speeds, then fall into the velocity packets.
      6'd1: c = cw_alu(ALU_MUL_L);
      6'd2: c = cw_alu(ALU_SAT_A);
      6'd3: c = cw_alu(ALU_MUL_R);
      6'd4: c = cw_alu(ALU_SAT_B);
      6'd5: c = cw_byte(SRC_ADDR, CSEL_VEL_FIRST, WSEL_CNT_A, 2'd0);
      6'd6: c = cw_byte(SRC_CMD, CSEL_VEL_FIRST, WSEL_CNT_A, 2'd0);
      6'd7, 6'd8, 6'd9, 6'd10:
        c = cw_byte(SRC_WORD, CSEL_VEL_FIRST, WSEL_CNT_A, 2'(pc - 6'd7));
      6'd11: c = cw_byte(SRC_CRC_HI, CSEL_VEL_FIRST, WSEL_CNT_A, 2'd0);
      6'd12: c = cw_crc_lo(1'b0);
      6'd13: c = cw_byte(SRC_ADDR, CSEL_VEL_SECOND, WSEL_CNT_B, 2'd0);
      6'd14: c = cw_byte(SRC_CMD, CSEL_VEL_SECOND, WSEL_CNT_B, 2'd0);
      6'd15, 6'd16, 6'd17, 6'd18:
        c = cw_byte(SRC_WORD, CSEL_VEL_SECOND, WSEL_CNT_B, 2'(pc - 6'd15));
      6'd19: c = cw_byte(SRC_CRC_HI, CSEL_VEL_SECOND, WSEL_CNT_B, 2'd0);
      6'd20: c = cw_crc_lo(1'b1);
      // Emergency stop: zero both counts and reuse the velocity packets.
      6'd21: begin
        c = cw_alu(ALU_ZERO);
        c.jmp    = JMP_GOTO;
        c.target = PC_VEL;
      end
      6'd22: c = cw_byte(SRC_ADDR, CSEL_PID, WSEL_GAIN_D, 2'd0);
      6'd23: c = cw_byte(SRC_CMD, CSEL_PID, WSEL_GAIN_D, 2'd0);
      6'd24, 6'd25, 6'd26, 6'd27:
        c = cw_byte(SRC_WORD, CSEL_PID, WSEL_GAIN_D, 2'(pc - 6'd24));
      6'd28, 6'd29, 6'd30, 6'd31:
        c = cw_byte(SRC_WORD, CSEL_PID, WSEL_GAIN_P, 2'(pc - 6'd28));
      6'd32, 6'd33, 6'd34, 6'd35:
        c = cw_byte(SRC_WORD, CSEL_PID, WSEL_GAIN_I, 2'(pc - 6'd32));
      6'd36, 6'd37, 6'd38, 6'd39:
        c = cw_byte(SRC_WORD, CSEL_PID, WSEL_MAX, 2'(pc - 6'd36));
      6'd40: c = cw_byte(SRC_CRC_HI, CSEL_PID, WSEL_GAIN_D, 2'd0);
      6'd41: c = cw_crc_lo(1'b1);
      6'd42: c = cw_byte(SRC_ADDR, CSEL_RESET_ENC, WSEL_CNT_A, 2'd0);
      6'd43: c = cw_byte(SRC_CMD, CSEL_RESET_ENC, WSEL_CNT_A, 2'd0);
      6'd44: c = cw_byte(SRC_CRC_HI, CSEL_RESET_ENC, WSEL_CNT_A, 2'd0);
      6'd45: c = cw_crc_lo(1'b1);
      default: begin
        c = cw_idle();
        c.jmp = JMP_END;
      end
    endcase
    return c;
  endfunction

endpackage

[rtl/core/mcpf_if.sv]
// Valid/ready channel interfaces for the motor command packet framer.
// mcpf_in_if carries one command item per beat, mcpf_out_if one packet byte per beat.
// No dependencies.
interface mcpf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic               motor_select;
  logic signed [31:0] speed_left;
  logic signed [31:0] speed_right;
  logic [31:0]        gain_p_bits;
  logic [31:0]        gain_i_bits;
  logic [31:0]        gain_d_bits;
  logic [30:0]        max_speed;
  logic               stop_level;

  modport source (
    output valid, opcode, motor_select, speed_left, speed_right,
           gain_p_bits, gain_i_bits, gain_d_bits, max_speed, stop_level,
    input  ready
  );
  modport sink (
    input  valid, opcode, motor_select, speed_left, speed_right,
           gain_p_bits, gain_i_bits, gain_d_bits, max_speed, stop_level,
    output ready
  );
endinterface

interface mcpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       packet_end;
  logic       item_end;

  modport source (output valid, tx_byte, packet_end, item_end, input ready);
  modport sink   (input valid, tx_byte, packet_end, item_end, output ready);
endinterface

[rtl/core/mcpf_seq.sv]
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on mcpf_pkg for the control word and the microprogram.
module mcpf_seq
  import mcpf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dp_stat_t stat,
  output dp_ctrl_t ctl
);

  logic  busy_r, busy_nxt;
  pc_t   pc_r, pc_nxt;
  ctrl_t cw;
  logic  go;

  assign cw = mcpf_rom(pc_r);
  // A byte step waits until the output register can take its byte.
  assign go = busy_r && ((cw.src == SRC_NONE) || stat.out_free);

  assign ctl.cw   = cw;
  assign ctl.go   = go;
  assign ctl.busy = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (!busy_r) begin
      if (stat.in_fire) begin
        busy_nxt = 1'b1;
        pc_nxt   = PC_DISPATCH;
      end
    end else if (go) begin
      case (cw.jmp)
        JMP_NEXT: pc_nxt = pc_r + 6'd1;
        JMP_GOTO: pc_nxt = cw.target;
        JMP_DISPATCH: begin
          case (stat.opcode)
            OP_DRIVE: begin
              if (stat.stop_active) begin
                busy_nxt = 1'b0;
              end else begin
                pc_nxt = PC_DRIVE;
              end
            end
            OP_PID:       pc_nxt = PC_PID;
            OP_RESET_ENC: pc_nxt = PC_RESET_ENC;
            OP_ESTOP: begin
              if (stat.stop_level) begin
                pc_nxt = PC_ESTOP;
              end else begin
                busy_nxt = 1'b0;
              end
            end
            default: busy_nxt = 1'b0;
          endcase
        end
        JMP_END: busy_nxt = 1'b0;
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= PC_DISPATCH;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

endmodule

[rtl/core/mcpf_dp.sv]
// Datapath: item and configuration registers, speed conversion, byte select, CRC
// and the output register. Driven by the control word from mcpf_seq.
// Depends on mcpf_pkg and the channel interfaces in mcpf_if.sv.
module mcpf_dp
  import mcpf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  mcpf_in_if.sink         in_ch,
  mcpf_out_if.source      out_ch,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  input  dp_ctrl_t        ctl,
  output dp_stat_t        stat
);

  logic        in_fire;
  op_t         op_r;
  logic        msel_r;
  logic [31:0] spd_l_r, spd_rt_r;
  logic [31:0] gain_p_r, gain_i_r, gain_d_r;
  logic [30:0] max_r;
  logic        lvl_r;

  logic [7:0]  addr_r;
  logic [31:0] cpm_r;
  logic        stop_r;
  logic [15:0] crc_r;

  logic [31:0] mul_src, mul_mag;
  logic        mul_neg;
  logic [63:0] prod_r;
  logic        neg_r;
  logic [63:0] rnd;
  logic [39:0] rnd_int;
  logic [31:0] sat_val;
  logic [31:0] cnt_a_r, cnt_b_r;

  logic [31:0] word_val;
  logic [7:0]  word_byte, cmd_byte, tx;
  logic [15:0] crc_base, crc_new;
  logic        emit, feed;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_pend_r, out_iend_r;
  logic        out_free;

  assign in_ch.ready = !ctl.busy;
  assign in_fire     = in_ch.valid && !ctl.busy;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign stat.in_fire     = in_fire;
  assign stat.opcode      = op_r;
  assign stat.stop_active = stop_r;
  assign stat.stop_level  = lvl_r;
  assign stat.out_free    = out_free;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= op_t'(in_ch.opcode);
      msel_r   <= in_ch.motor_select;
      spd_l_r  <= in_ch.speed_left;
      spd_rt_r <= in_ch.speed_right;
      gain_p_r <= in_ch.gain_p_bits;
      gain_i_r <= in_ch.gain_i_bits;
      gain_d_r <= in_ch.gain_d_bits;
      max_r    <= in_ch.max_speed;
      lvl_r    <= in_ch.stop_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_RESET;
      cpm_r  <= CPM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS:   addr_r <= cfg_data[7:0];
        CFG_COUNTS_PER_METER: cpm_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sign-magnitude multiply; the most negative speed keeps magnitude 2^31.
  always_comb begin
    mul_src = (ctl.cw.alu == ALU_MUL_R) ? spd_rt_r : spd_l_r;
    mul_neg = mul_src[31];
    mul_mag = mul_neg ? (~mul_src + 32'd1) : mul_src;
  end

  always_ff @(posedge clk) begin
    if (ctl.go && (ctl.cw.alu == ALU_MUL_L || ctl.cw.alu == ALU_MUL_R)) begin
      prod_r <= mul_mag * cpm_r;
      neg_r  <= mul_neg;
    end
  end

  // Round half away from zero on the magnitude, then clamp to the int32 range.
  always_comb begin
    rnd     = prod_r + ROUND_HALF;
    rnd_int = rnd[63:24];
    if (neg_r) begin
      sat_val = (rnd_int >= NEG_LIMIT) ? INT32_MIN : (~rnd_int[31:0] + 32'd1);
    end else begin
      sat_val = (rnd_int > POS_LIMIT) ? INT32_MAX : rnd_int[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      case (ctl.cw.alu)
        ALU_SAT_A: cnt_a_r <= sat_val;
        ALU_SAT_B: cnt_b_r <= sat_val;
        ALU_ZERO: begin
          cnt_a_r <= '0;
          cnt_b_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ctl.cw.word)
      WSEL_CNT_A:  word_val = cnt_a_r;
      WSEL_CNT_B:  word_val = cnt_b_r;
      WSEL_GAIN_D: word_val = gain_d_r;
      WSEL_GAIN_P: word_val = gain_p_r;
      WSEL_GAIN_I: word_val = gain_i_r;
      WSEL_MAX:    word_val = {1'b0, max_r};
      default:     word_val = '0;
    endcase

    case (ctl.cw.byte_idx)
      2'd0:    word_byte = word_val[31:24];
      2'd1:    word_byte = word_val[23:16];
      2'd2:    word_byte = word_val[15:8];
      default: word_byte = word_val[7:0];
    endcase

    case (ctl.cw.cmd)
      CSEL_VEL_FIRST:  cmd_byte = CMD_VEL_FIRST;
      CSEL_VEL_SECOND: cmd_byte = CMD_VEL_SECOND;
      CSEL_PID:        cmd_byte = msel_r ? CMD_PID_SECOND : CMD_PID_FIRST;
      CSEL_RESET_ENC:  cmd_byte = CMD_RESET_ENC;
      default:         cmd_byte = CMD_RESET_ENC;
    endcase

    case (ctl.cw.src)
      SRC_ADDR:   tx = addr_r;
      SRC_CMD:    tx = cmd_byte;
      SRC_WORD:   tx = word_byte;
      SRC_CRC_HI: tx = crc_r[15:8];
      SRC_CRC_LO: tx = crc_r[7:0];
      default:    tx = 8'h00;
    endcase

    emit     = (ctl.cw.src != SRC_NONE);
    feed     = (ctl.cw.src == SRC_ADDR) || (ctl.cw.src == SRC_CMD) ||
               (ctl.cw.src == SRC_WORD);
    crc_base = ctl.cw.crc_clr ? 16'h0000 : crc_r;
    crc_new  = crc_byte(crc_base, tx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= '0;
      stop_r <= 1'b0;
    end else if (ctl.go) begin
      if (feed) begin
        crc_r <= crc_new;
      end
      if (ctl.cw.jmp == JMP_DISPATCH && op_r == OP_ESTOP) begin
        stop_r <= lvl_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go && emit) begin
      out_byte_r <= tx;
      out_pend_r <= ctl.cw.pkt_end;
      out_iend_r <= ctl.cw.item_end;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.tx_byte    = out_byte_r;
  assign out_ch.packet_end = out_pend_r;
  assign out_ch.item_end   = out_iend_r;

endmodule

[rtl/core/motor_command_packet_framer.sv]
// Motor command packet framer. Each accepted command becomes zero to twenty serial
// bytes, framed as address, command, payload and a CRC-16/XMODEM sent high byte
// first. A small microprogram walks one step per clock; each byte step loads the
// output register, so one byte leaves per cycle while the consumer keeps up. After
// the accepting edge an item takes 21 steps for drive and for set pid, 18 for an
// active emergency stop, 5 for reset encoders and 1 for an item with no bytes
// (drive while stopped, stop release); a byte step also waits while the output
// register holds a byte that has not been taken. The next item is accepted in the
// cycle after the last step. Drive speeds go through one 32x32 multiplier, one
// speed after the other. A configuration write can also change an item in progress.
// Depends on mcpf_pkg, mcpf_if.sv, mcpf_seq and mcpf_dp.
module motor_command_packet_framer
  import mcpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mcpf_in_if.sink     in_chan,
  mcpf_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dp_ctrl_t ctl;
  dp_stat_t stat;

  mcpf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  mcpf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_chan),
    .out_ch    (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule

[rtl/core/mcpf_checker.sv]
// Port-level checks for motor_command_packet_framer, and the bind that attaches them.
// Sees only the top-level handshake and result ports; no package needed.
module mcpf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] tx_byte,
  input logic       packet_end,
  input logic       item_end
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(item_end)
      && $stable(packet_end))
    else $error("result beat changed while stalled");

  // The last byte of an item always closes a packet.
  a_item_closes_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && item_end |-> packet_end)
    else $error("item ended inside a packet");

  // While a byte of an unfinished item waits, no new item may be taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !item_end |-> !in_ready)
    else $error("input ready while an item is still being framed");

  // An accepted item occupies the block for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted beat");

endmodule

bind motor_command_packet_framer mcpf_checker u_mcpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .tx_byte    (out_chan.tx_byte),
  .packet_end (out_chan.packet_end),
  .item_end   (out_chan.item_end)
);
